// ===== rtl/rtac_pkg.sv =====
package rtac_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_CHECK = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DENIED   = 3'd1,
        ST_NULL     = 3'd2,
        ST_FULL     = 3'd3,
        ST_ORDER    = 3'd4
    } t_status;

    typedef struct packed {
        t_op         op;
        logic        bad_ptr;
        logic [63:0] ptr;
        logic [63:0] stop;
        logic [63:0] ext;
        logic [2:0]  perms;
        logic [2:0]  need;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD_RD,
        S_LOAD_CHK,
        S_HIT_RD,
        S_HIT_CHK,
        S_BS_RD,
        S_BS_CHK,
        S_FIN_RD,
        S_FIN_CHK,
        S_DONE
    } t_state;

endpackage

// ===== rtl/rtac_front.sv =====
module rtac_front
    import rtac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_address,
    input  logic [63:0] i_extent,
    input  logic        i_allow_read,
    input  logic        i_allow_write,
    input  logic        i_allow_execute,
    input  logic [1:0]  i_access_kind,
    input  logic        i_untag,
    output logic        o_q_valid,
    output t_cmd        o_q_cmd,
    input  logic        i_q_pop,
    input  logic        i_back_idle
);

    logic        r_full;
    t_cmd        r_cmd;
    t_cmd        n_cmd;
    logic [63:0] w_ptr;
    logic [64:0] w_sum;

    // One item is held from acceptance until its result is delivered.
    assign o_busy    = r_full || !i_back_idle;
    assign o_q_valid = r_full;
    assign o_q_cmd   = r_cmd;

    always_comb begin
        w_sum = {1'b0, i_address} + {1'b0, i_extent};
        w_ptr = (i_untag && t_op'(i_operation) == OP_CHECK) ? {8'd0, i_address[55:0]}
                                                             : i_address;
        n_cmd.op      = t_op'(i_operation);
        n_cmd.bad_ptr = (i_address == 64'd0) || w_sum[64];
        n_cmd.ptr     = w_ptr;
        n_cmd.stop    = w_ptr + i_extent;
        n_cmd.ext     = i_extent;
        n_cmd.perms   = {i_allow_execute, i_allow_write, i_allow_read};
        case (i_access_kind)
            2'd0:    n_cmd.need = 3'b001;
            2'd1:    n_cmd.need = 3'b010;
            2'd2:    n_cmd.need = 3'b100;
            default: n_cmd.need = 3'b000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_start && !o_busy) begin
            r_full <= 1'b1;
        end else if (i_q_pop) begin
            r_full <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/rtac_back.sv =====
module rtac_back
    import rtac_pkg::*;
#(
    parameter int MAX_REGIONS = 64,
    parameter int IW = $clog2(MAX_REGIONS),
    parameter int CW = $clog2(MAX_REGIONS + 1)
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  t_cmd          i_q_cmd,
    output logic          o_q_pop,
    output logic          o_idle,
    output logic          o_done,
    output logic [2:0]    o_status,
    output logic [CW-1:0] o_count
);

    logic [63:0] mem_start [MAX_REGIONS];
    logic [63:0] mem_end   [MAX_REGIONS];
    logic [2:0]  mem_perms [MAX_REGIONS];

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_last, n_last;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [2:0]    r_status, n_status;
    logic [IW-1:0] w_raddr;
    logic [63:0]   r_rs, r_re;
    logic [2:0]    r_rp;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [63:0]   w_ws, w_we_end;
    logic [2:0]    w_wp;
    logic [CW-1:0] w_mid;
    logic [CW-1:0] w_lcnt;

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_status = r_status;
    assign o_count  = r_count;
    assign w_mid    = r_lo + ((r_hi - r_lo) >> 1);
    assign w_lcnt   = r_count - CW'(1);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_start[w_waddr] <= w_ws;
            mem_end[w_waddr]   <= w_we_end;
            mem_perms[w_waddr] <= w_wp;
        end
        r_rs <= mem_start[w_raddr];
        r_re <= mem_end[w_raddr];
        r_rp <= mem_perms[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_last  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_status <= n_status;
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_count  = r_count;
        n_last   = r_last;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_status = r_status;
        o_q_pop  = 1'b0;
        w_raddr  = r_last;
        w_we     = 1'b0;
        w_waddr  = w_lcnt[IW-1:0];
        w_ws     = r_rs;
        w_we_end = r_cmd.ext;
        w_wp     = r_rp;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop  = 1'b1;
                    n_cmd    = i_q_cmd;
                    n_status = ST_OK;
                    case (i_q_cmd.op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_last  = '0;
                            n_state = S_DONE;
                        end
                        OP_LOAD: begin
                            if (i_q_cmd.ext <= i_q_cmd.ptr) begin
                                n_status = ST_ORDER;
                                n_state  = S_DONE;
                            end else if (r_count == '0) begin
                                n_state = S_LOAD_CHK;
                            end else begin
                                w_raddr = w_lcnt[IW-1:0];
                                n_state = S_LOAD_RD;
                            end
                        end
                        OP_CHECK: begin
                            if (i_q_cmd.bad_ptr) begin
                                n_status = ST_NULL;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_HIT_RD;
                            end
                        end
                        default: begin
                            n_status = ST_DENIED;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD_RD: begin
                w_raddr = w_lcnt[IW-1:0];
                n_state = S_LOAD_CHK;
            end
            S_LOAD_CHK: begin
                n_state = S_DONE;
                if (r_count != '0 && r_cmd.ptr < r_re) begin
                    n_status = ST_ORDER;
                end else if (r_count != '0 && r_cmd.ptr == r_re
                             && r_cmd.perms == r_rp) begin
                    w_we = 1'b1;
                end else if (r_count == CW'(MAX_REGIONS)) begin
                    n_status = ST_FULL;
                end else begin
                    w_we     = 1'b1;
                    w_waddr  = r_count[IW-1:0];
                    w_ws     = r_cmd.ptr;
                    w_wp     = r_cmd.perms;
                    n_count  = r_count + CW'(1);
                end
            end
            S_HIT_RD: begin
                if (r_cmd.ext == 64'd0 && r_cmd.ptr == 64'd0) begin
                    n_state = S_DONE;
                end else if (r_count == '0) begin
                    n_status = ST_DENIED;
                    n_state  = S_DONE;
                end else begin
                    w_raddr = r_last;
                    n_state = S_HIT_CHK;
                end
            end
            S_HIT_CHK: begin
                if (CW'(r_last) < r_count && r_rs <= r_cmd.ptr
                    && r_cmd.ptr < r_re) begin
                    n_state = S_FIN_CHK;
                end else begin
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_state = S_BS_RD;
                end
            end
            S_BS_RD: begin
                if (r_lo < r_hi) begin
                    w_raddr = w_mid[IW-1:0];
                    n_state = S_BS_CHK;
                end else if (r_lo < r_count) begin
                    w_raddr = r_lo[IW-1:0];
                    n_state = S_FIN_RD;
                end else begin
                    n_status = ST_DENIED;
                    n_state  = S_DONE;
                end
            end
            S_BS_CHK: begin
                if (r_re <= r_cmd.ptr) begin
                    n_lo = w_mid + CW'(1);
                end else begin
                    n_hi = w_mid;
                end
                n_state = S_BS_RD;
            end
            S_FIN_RD: begin
                w_raddr = r_lo[IW-1:0];
                if (r_rs <= r_cmd.ptr && r_cmd.ptr < r_re) begin
                    n_last  = r_lo[IW-1:0];
                    n_state = S_FIN_CHK;
                end else begin
                    n_status = ST_DENIED;
                    n_state  = S_DONE;
                end
            end
            S_FIN_CHK: begin
                if ((r_rp & r_cmd.need) == 3'b000) begin
                    n_status = ST_DENIED;
                    n_state  = S_DONE;
                end else if (r_re >= r_cmd.stop) begin
                    n_state = S_DONE;
                end else begin
                    n_cmd.ptr = r_re;
                    w_raddr   = r_last;
                    n_state   = S_HIT_CHK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/region_table_access_checker.sv =====
// An item is accepted when start is high and busy is low; its result
// appears on o_status and o_entries_used for one cycle with o_done, which the
// receiver cannot stall. Clear, unknown and rejected items finish without a
// table lookup; a load reads the last region, if any, and a check tries the
// last-used region before a binary search. Each further region a range spans
// repeats that lookup, and every table read goes through the single registered
// read port of the region table.
module region_table_access_checker
    import rtac_pkg::*;
#(
    parameter int MAX_REGIONS = 64
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_address,
    input  logic [63:0] i_extent,
    input  logic        i_allow_read,
    input  logic        i_allow_write,
    input  logic        i_allow_execute,
    input  logic [1:0]  i_access_kind,
    output logic        o_done,
    output logic [2:0]  o_status,
    output logic [6:0]  o_entries_used,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);

    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic          r_untag;
    logic          w_q_valid, w_q_pop, w_idle;
    t_cmd          w_q_cmd;
    logic [CW-1:0] w_count;

    assign o_cfg_ready    = 1'b1;
    assign o_entries_used = 7'(w_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_untag <= 1'b1;
        end else if (i_cfg_valid) begin
            r_untag <= i_cfg_data;
        end
    end

    rtac_front u_front (
        .i_clk, .i_rst_n,
        .i_start(start), .o_busy(busy),
        .i_operation, .i_address, .i_extent,
        .i_allow_read, .i_allow_write, .i_allow_execute, .i_access_kind,
        .i_untag(r_untag),
        .o_q_valid(w_q_valid), .o_q_cmd(w_q_cmd), .i_q_pop(w_q_pop),
        .i_back_idle(w_idle)
    );

    rtac_back #(.MAX_REGIONS(MAX_REGIONS)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(w_q_valid), .i_q_cmd(w_q_cmd), .o_q_pop(w_q_pop),
        .o_idle(w_idle), .o_done, .o_status, .o_count(w_count)
    );

endmodule

// ===== bench/region_table_access_checker_monitor.sv =====
`timescale 1ns / 1ps

module region_table_access_checker_monitor
    import rtac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_address,
    input  logic [63:0] i_extent,
    input  logic        i_allow_read,
    input  logic        i_allow_write,
    input  logic        i_allow_execute,
    input  logic [1:0]  i_access_kind,
    input  logic        o_done,
    input  logic [2:0]  o_status,
    input  logic [6:0]  o_entries_used,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic        i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int TABLE_DEPTH = 64;

    typedef struct packed {
        t_status    status;
        logic [6:0] used;
    } t_verdict;

    logic [63:0] tbl_start [TABLE_DEPTH];
    logic [63:0] tbl_end   [TABLE_DEPTH];
    logic [2:0]  tbl_perms [TABLE_DEPTH];
    int          tbl_count;
    int          hit_index;
    logic        untag;
    t_verdict    verdicts_due [$];

    function automatic int find_region(logic [63:0] a);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = tbl_count;
        if (tbl_count == 0) begin
            return -1;
        end
        if (hit_index < tbl_count && tbl_start[hit_index] <= a && a < tbl_end[hit_index]) begin
            return hit_index;
        end
        while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (tbl_end[mid] <= a) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        if (lo < tbl_count && tbl_start[lo] <= a && a < tbl_end[lo]) begin
            hit_index = lo;
            return lo;
        end
        return -1;
    endfunction

    function automatic t_status load_region(logic [63:0] s, logic [63:0] e, logic [2:0] p);
        int last;
        if (e <= s) begin
            return ST_ORDER;
        end
        if (tbl_count > 0) begin
            last = tbl_count - 1;
            if (s < tbl_end[last]) begin
                return ST_ORDER;
            end
            if (s == tbl_end[last] && p == tbl_perms[last]) begin
                tbl_end[last] = e;
                return ST_OK;
            end
        end
        if (tbl_count >= TABLE_DEPTH) begin
            return ST_FULL;
        end
        tbl_start[tbl_count] = s;
        tbl_end[tbl_count] = e;
        tbl_perms[tbl_count] = p;
        tbl_count++;
        return ST_OK;
    endfunction

    function automatic t_status check_access(logic [63:0] ptr, logic [63:0] len,
                                             logic [1:0] kind);
        logic [63:0] stop;
        logic [63:0] seen_end;
        logic [2:0]  need;
        int          idx;
        seen_end = '0;
        if (ptr == 0 || ptr + len < ptr) begin
            return ST_NULL;
        end
        if (untag) begin
            ptr[63:56] = 8'h00;
        end
        stop = ptr + len;
        need = (kind < 2'd3) ? 3'(1 << kind) : 3'd0;
        while (seen_end < stop) begin
            idx = find_region(ptr);
            if (idx < 0 || need == 0 || (tbl_perms[idx] & need) == 0) begin
                return ST_DENIED;
            end
            seen_end = tbl_end[idx];
            ptr = seen_end;
        end
        return ST_OK;
    endfunction

    assign o_pending = verdicts_due.size();

    always @(posedge i_clk) begin
        t_verdict want;
        t_status  st;
        if (!i_rst_n) begin
            tbl_count <= 0;
            hit_index <= 0;
            untag <= 1'b1;
            o_fail_count <= 0;
            verdicts_due.delete();
        end else begin
            if (o_done) begin
                if (verdicts_due.size() == 0) begin
                    o_fail_count <= o_fail_count + 1;
                    if (o_fail_count < 10) begin
                        $display("Unexpected result word: status %0d used %0d",
                                 o_status, o_entries_used);
                    end
                end else begin
                    want = verdicts_due.pop_front();
                    if (o_status !== want.status || o_entries_used !== want.used) begin
                        o_fail_count <= o_fail_count + 1;
                        if (o_fail_count < 10) begin
                            $display("Mismatch: status exp %0d got %0d, used exp %0d got %0d",
                                     want.status, o_status, want.used, o_entries_used);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                untag = i_cfg_data;
            end
            if (start && !busy) begin
                case (t_op'(i_operation))
                    OP_CLEAR: begin
                        tbl_count = 0;
                        hit_index = 0;
                        st = ST_OK;
                    end
                    OP_LOAD: begin
                        st = load_region(i_address, i_extent,
                                         {i_allow_execute, i_allow_write, i_allow_read});
                    end
                    OP_CHECK: begin
                        st = check_access(i_address, i_extent, i_access_kind);
                    end
                    default: begin
                        st = ST_DENIED;
                    end
                endcase
                want.status = st;
                want.used = 7'(tbl_count);
                verdicts_due.push_back(want);
            end
        end
    end

endmodule

// ===== bench/region_table_access_checker_test.sv =====
`timescale 1ns / 1ps

module region_table_access_checker_test;
    import rtac_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int TARGET_ITEMS = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_operation;
    logic [63:0] i_address;
    logic [63:0] i_extent;
    logic        i_allow_read;
    logic        i_allow_write;
    logic        i_allow_execute;
    logic [1:0]  i_access_kind;
    logic        o_done;
    logic [2:0]  o_status;
    logic [6:0]  o_entries_used;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    int          items_sent;
    logic [63:0] base_addr;
    logic [63:0] fill_end;

    region_table_access_checker dut (.*);

    region_table_access_checker_monitor monitor (
        .i_clk, .i_rst_n, .start, .busy, .i_operation, .i_address, .i_extent,
        .i_allow_read, .i_allow_write, .i_allow_execute, .i_access_kind,
        .o_done, .o_status, .o_entries_used, .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_word(t_op op, logic [63:0] addr, logic [63:0] ext,
                             logic [2:0] perms, logic [1:0] kind);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        i_extent <= ext;
        {i_allow_execute, i_allow_write, i_allow_read} <= perms;
        i_access_kind <= kind;
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_untag(logic value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        i_cfg_data <= $urandom_range(0, 1);
    endtask

    task automatic load_next();
        logic [63:0] s;
        logic [63:0] e;
        int r;
        r = $urandom_range(0, 99);
        s = (r < 35) ? fill_end : fill_end + $urandom_range(1, 64);
        e = s + ((r % 7 == 0) ? $urandom_range(1, 100000) : $urandom_range(1, 512));
        if (r >= 95) begin
            send_word(OP_LOAD, fill_end - $urandom_range(1, 16), e, 3'($urandom), 2'd0);
        end else if (r >= 92) begin
            send_word(OP_LOAD, s, s - $urandom_range(0, 3), 3'($urandom), 2'd0);
        end else begin
            send_word(OP_LOAD, s, e, 3'($urandom), 2'd0);
            fill_end = e;
        end
    endtask

    task automatic check_random(logic untagged);
        logic [63:0] ptr;
        logic [63:0] len;
        int r;
        r = $urandom_range(0, 99);
        ptr = base_addr + (rand64() % (fill_end - base_addr + 32));
        case ($urandom_range(0, 3))
            0: len = 0;
            1: len = $urandom_range(1, 16);
            2: len = $urandom_range(1, 2000);
            default: len = rand64() % (fill_end - ptr + 64);
        endcase
        if (untagged && r < 30) begin
            ptr[63:56] = 8'($urandom);
        end
        if (r >= 96) begin
            send_word(OP_CHECK, 64'd0, len, 3'($urandom), 2'($urandom));
        end else if (r >= 93) begin
            send_word(OP_CHECK, rand64() | 64'hFF00_0000_0000_0000, rand64(),
                      3'($urandom), 2'($urandom));
        end else if (r >= 91) begin
            send_word(OP_NONE, rand64(), rand64(), 3'($urandom), 2'($urandom));
        end else if (r >= 88) begin
            send_word(OP_CHECK, rand64(), rand64(), 3'($urandom), 2'($urandom));
        end else begin
            send_word(OP_CHECK, ptr, len, 3'($urandom), 2'($urandom_range(0, 3)));
        end
    endtask

    initial begin
        logic untag_now;
        int n_loads;
        cycles = 0;
        items_sent = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_CLEAR;
        i_address = '0;
        i_extent = '0;
        i_allow_read = 1'b0;
        i_allow_write = 1'b0;
        i_allow_execute = 1'b0;
        i_access_kind = 2'd0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(OP_CHECK, 64'h10, 64'd4, 3'd0, 2'd0);
        send_word(OP_LOAD, 64'd0, 64'd1, 3'd1, 2'd0);
        send_word(OP_LOAD, 64'd1, 64'h100, 3'd1, 2'd0);
        send_word(OP_LOAD, 64'h80, 64'h200, 3'd7, 2'd0);
        send_word(OP_LOAD, 64'h300, 64'h300, 3'd7, 2'd0);
        send_word(OP_LOAD, 64'h100, 64'h180, 3'd6, 2'd0);
        send_word(OP_LOAD, 64'h180, 64'h400, 3'd7, 2'd0);
        send_word(OP_LOAD, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 3'd5, 2'd0);
        send_word(OP_CHECK, 64'd0, 64'd8, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'h10, 64'd0, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'h10, 64'h200, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'h10, 64'h200, 3'd0, 2'd1);
        send_word(OP_CHECK, 64'h150, 64'h10, 3'd0, 2'd2);
        send_word(OP_CHECK, 64'h150, 64'h10, 3'd0, 2'd3);
        send_word(OP_CHECK, 64'hAB00_0000_0000_0020, 64'd4, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'hFF00_0000_0000_0000, 64'd0, 3'd0, 2'd0);
        send_word(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd7, 2'd3);
        write_untag(1'b0);
        send_word(OP_CHECK, 64'hAB00_0000_0000_0020, 64'd4, 3'd0, 2'd0);
        send_word(OP_CHECK, 64'hFFFF_FFFF_FFFF_FF10, 64'h10, 3'd0, 2'd2);
        send_word(OP_CLEAR, 64'd0, 64'd0, 3'd0, 2'd0);
        untag_now = 1'b0;

        while (items_sent < TARGET_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                untag_now = ~untag_now;
                write_untag(untag_now);
            end
            send_word(OP_CLEAR, rand64(), rand64(), 3'($urandom), 2'($urandom));
            base_addr = rand64();
            if (untag_now || $urandom_range(0, 1) == 0) begin
                base_addr[63:55] = 9'd0;
            end
            fill_end = base_addr;
            n_loads = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 75)
                                                  : $urandom_range(1, 20);
            repeat (n_loads) load_next();
            repeat ($urandom_range(10, 30)) check_random(untag_now);
            if ($urandom_range(0, 3) == 0) begin
                load_next();
                repeat (3) check_random(untag_now);
            end
            if ($urandom_range(0, 4) == 0) begin
                drain();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
